FILE: rtl/crc16bs_pkg.sv
package crc16bs_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned CRC_W  = 16;

    localparam logic [CRC_W-1:0] CRC_POLY   = 16'h8005;
    localparam logic [CRC_W-1:0] CRC_INIT   = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_XOROUT = 16'hFFFF;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [CRC_W-1:0]  crc_t;

    typedef struct packed {
        data_t data_byte;
        logic  last_byte;
    } item_t;

    // MSB-first division of the register by the polynomial, eight bits per byte
    function automatic crc_t crc_update_byte(input crc_t crc, input data_t data);
        crc_t r;
        r = crc ^ {data, {(CRC_W-DATA_W){1'b0}}};
        for (int k = 0; k < DATA_W; k++)
        begin
            if (r[CRC_W-1])
            begin
                r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/crc16bs_byte_if.sv
interface crc16bs_byte_if;
    import crc16bs_pkg::*;

    logic  valid;
    logic  ready;
    data_t data_byte;
    logic  last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/crc16bs_crc_if.sv
interface crc16bs_crc_if;
    import crc16bs_pkg::*;

    logic valid;
    logic ready;
    crc_t crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

FILE: rtl/crc16_byte_stream_core.sv
// CRC-16 (poly 0x8005, MSB first, init 0xFFFF, xorout 0xFFFF) over a byte stream.
// Throughput: one byte per cycle unless a last byte waits on a full result register.
// The byte update is one XOR network per clock, fed from the input register.
// A full result register stalls only the last byte; earlier bytes keep flowing.
// Reset (rst_n low, asynchronous) empties both stages and loads the CRC with 0xFFFF.
module crc16_byte_stream_core (
    input  logic          clk,
    input  logic          rst_n,
    crc16bs_byte_if.sink  byte_in,
    crc16bs_crc_if.source crc_out
);
    import crc16bs_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_take;

    crc16bs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    crc16bs_crc_stage u_crc_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .crc_out    (crc_out)
    );

endmodule

FILE: rtl/crc16bs_in_stage.sv
module crc16bs_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    crc16bs_byte_if.sink        byte_in,
    output logic                item_valid,
    output crc16bs_pkg::item_t  item,
    input  logic                item_take
);
    import crc16bs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Take a new request whenever the held one is empty or leaves this cycle
    assign byte_in.ready = !valid_reg || item_take;
    assign load          = byte_in.valid && byte_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data_byte <= byte_in.data_byte;
            item_reg.last_byte <= byte_in.last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/crc16bs_crc_stage.sv
module crc16bs_crc_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  crc16bs_pkg::item_t  item,
    output logic                item_take,
    crc16bs_crc_if.source       crc_out
);
    import crc16bs_pkg::*;

    crc_t crc_reg;
    crc_t crc_next;
    crc_t crc_upd;
    logic out_valid_reg;
    logic out_valid_next;
    crc_t out_crc_reg;
    logic out_free;
    logic emit;

    assign out_free  = !out_valid_reg || crc_out.ready;
    // Plain bytes always advance; the last one waits for room in the result register
    assign item_take = item_valid && (!item.last_byte || out_free);
    assign emit      = item_take && item.last_byte;
    assign crc_upd   = crc_update_byte(crc_reg, item.data_byte);

    always_comb
    begin
        crc_next = crc_reg;
        if (item_take)
        begin
            crc_next = item.last_byte ? CRC_INIT : crc_upd;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (crc_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_crc_reg <= crc_upd ^ CRC_XOROUT;
        end
    end

    assign crc_out.valid     = out_valid_reg;
    assign crc_out.crc_value = out_crc_reg;

    a_restart_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (crc_reg == CRC_INIT))
        else $error("CRC register not restarted after last byte");

    a_result_from_last : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("result raised without a last byte");

    a_plain_byte_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !crc_out.ready && !emit) |=> $stable(out_crc_reg))
        else $error("held result changed without a last byte");

    a_hold_last_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item.last_byte && out_valid_reg && !crc_out.ready) |-> !item_take)
        else $error("last byte advanced into a full result register");

endmodule
